// File: rtl/core/sobel_pkg.sv
// Shared constants, register codes and arithmetic helpers of the Sobel edge block.
package sobel_pkg;

   localparam int PIX_W      = 8;
   localparam int ROW_W      = 12;
   localparam int CSR_W      = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int SUM_W      = 10;   // blue + green + red
   localparam int GRAD_W     = 12;   // signed gx / gy
   localparam int SQ_W       = 21;   // gx^2 + gy^2 fits here

   localparam int MIN_DIM      = 3;
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   // floor(s / 3) == (s * 683) >> 11 for every s up to 765
   localparam logic [SUM_W-1:0] GRAY_RECIP = 10'd683;
   localparam int               GRAY_SHIFT = 11;

   localparam logic [PIX_W-1:0] PIX_SAT  = 8'hFF;
   localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;

   // starting bit weights of the two root halves
   localparam logic [15:0] ROOT_BIT_HI = 16'h4000;
   localparam logic [15:0] ROOT_BIT_LO = 16'h0040;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_BINARY_MODE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [15:0] rem;
      logic [15:0] res;
   } root_part_type;

   // Four steps of a restoring square root of a 16-bit value, one result bit
   // per step, starting at weight bt_start.
   function automatic root_part_type isqrt_half(input root_part_type part,
                                               input logic [15:0]   bt_start);
      root_part_type nxt;
      logic [15:0]   bt;
      nxt = part;
      bt  = bt_start;
      for (int i = 0; i < 4; i++) begin
         if (nxt.rem >= nxt.res + bt) begin
            nxt.rem = nxt.rem - (nxt.res + bt);
            nxt.res = (nxt.res >> 1) + bt;
         end else begin
            nxt.res = nxt.res >> 1;
         end
         bt = bt >> 2;
      end
      return nxt;
   endfunction

endpackage

// File: rtl/core/sobel_edge_magnitude_top.sv
// Sobel 3x3 edge magnitude over a raster pixel stream, with two line memories.
//
// Pixels (blue, green, red) enter on the req_ channel in raster order, one beat
// per pixel. Each pixel becomes gray; once the 3x3 window is full (row >= 2 and
// column >= 2) one rsp_ beat carries the edge value for the window's top-left
// position. The last two rows and columns of a frame produce no beat.
// rsp_frame_done marks the last beat of a frame; positions then wrap to 0,0.
// Throughput: one pixel per cycle while the output is not stalled. The two line
// memories are read at accept and written back as the pixel leaves stage 1, at a
// different column, so the read-modify-write of each memory sets that rate.
// Stalls: the whole pipeline holds while rsp_valid is high and rsp_ready is
// low; req_ready is low for that time. The output register still lets the
// next pixel in on the same edge at which a waiting result is taken.
// Reset: width 640, height 480, magnitude mode, position 0,0, pipeline empty.
// Writing width or height restarts the frame; write the csr_ port only while
// the block is idle. Line memories hold no reset value.
module sobel_edge_magnitude_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [sobel_pkg::PIX_W-1:0]          req_blue,
   input  logic [sobel_pkg::PIX_W-1:0]          req_green,
   input  logic [sobel_pkg::PIX_W-1:0]          req_red,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sobel_pkg::ROW_W-1:0]          rsp_out_row,
   output logic [$clog2(MAX_WIDTH)-1:0]         rsp_out_col,
   output logic [sobel_pkg::PIX_W-1:0]          rsp_edge_value,
   output logic                                 rsp_frame_done,

   input  logic                                 csr_we,
   input  logic [sobel_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sobel_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int PIX_W    = sobel_pkg::PIX_W;
   localparam int ROW_W    = sobel_pkg::ROW_W;
   localparam int RST_W    = (sobel_pkg::RESET_WIDTH > MAX_WIDTH) ?
                             MAX_WIDTH : sobel_pkg::RESET_WIDTH;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             done;
   } meta_type;

   // ---------------- configuration ----------------
   logic [COL_W-1:0] last_col_ff, last_col_in;
   logic [ROW_W-1:0] last_row_ff, last_row_in;
   logic             binary_mode_ff;
   logic             restart_w;
   int unsigned      w_clamp;
   int unsigned      h_clamp;

   always_comb begin
      w_clamp = 32'(csr_wdata[10:0]);
      if (w_clamp < sobel_pkg::MIN_DIM) begin
         w_clamp = sobel_pkg::MIN_DIM;
      end else if (w_clamp > MAX_WIDTH) begin
         w_clamp = MAX_WIDTH;
      end
      h_clamp = 32'(csr_wdata[ROW_W-1:0]);
      if (h_clamp < sobel_pkg::MIN_DIM) begin
         h_clamp = sobel_pkg::MIN_DIM;
      end
      last_col_in = COL_W'(w_clamp - 1);
      last_row_in = ROW_W'(h_clamp - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff    <= COL_W'(RST_W - 1);
         last_row_ff    <= ROW_W'(sobel_pkg::RESET_HEIGHT - 1);
         binary_mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (sobel_pkg::csr_index_type'(csr_index))
            sobel_pkg::CSR_IMAGE_WIDTH: begin
               last_col_ff <= last_col_in;
            end
            sobel_pkg::CSR_IMAGE_HEIGHT: begin
               last_row_ff <= last_row_in;
            end
            sobel_pkg::CSR_BINARY_MODE: begin
               binary_mode_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign restart_w = csr_we &&
      (sobel_pkg::csr_index_type'(csr_index) == sobel_pkg::CSR_IMAGE_WIDTH ||
       sobel_pkg::csr_index_type'(csr_index) == sobel_pkg::CSR_IMAGE_HEIGHT);

   // ---------------- input position ----------------
   logic             adv;
   logic             accept;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   always_comb begin
      col_in = col_ff + COL_W'(1);
      row_in = row_ff;
      if (col_ff == last_col_ff) begin
         col_in = '0;
         row_in = (row_ff == last_row_ff) ? '0 : row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart_w) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // gray by reciprocal multiply
   logic [sobel_pkg::SUM_W-1:0] chan_sum;
   logic [2*sobel_pkg::SUM_W-1:0] gray_prod;
   assign chan_sum  = sobel_pkg::SUM_W'(req_blue) + sobel_pkg::SUM_W'(req_green)
                    + sobel_pkg::SUM_W'(req_red);
   assign gray_prod = chan_sum * sobel_pkg::GRAY_RECIP;

   // ---------------- stage 1: line memory read ----------------
   logic             v1_ff;
   logic [PIX_W-1:0] gray1_ff;
   meta_type         meta1_ff;
   logic [PIX_W-1:0] rd_up_ff;
   logic [PIX_W-1:0] rd_mid_ff;
   logic             wr_en;

   assign wr_en = adv && v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
      if (accept) begin
         gray1_ff      <= gray_prod[sobel_pkg::GRAY_SHIFT +: PIX_W];
         meta1_ff.row  <= row_ff;
         meta1_ff.col  <= col_ff;
         meta1_ff.done <= (row_ff == last_row_ff) && (col_ff == last_col_ff);
      end
   end

   // Read column c at accept, write column c as the pixel leaves stage 1. Consecutive
   // pixels never share a column, so read and write never collide.
   logic [PIX_W-1:0] mem_upper  [MAX_WIDTH];
   logic [PIX_W-1:0] mem_middle [MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_up_ff <= mem_upper[col_ff];
      end
      if (wr_en) begin
         mem_upper[meta1_ff.col] <= rd_mid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_mid_ff <= mem_middle[col_ff];
      end
      if (wr_en) begin
         mem_middle[meta1_ff.col] <= gray1_ff;
      end
   end

   // ---------------- stage 2: window ----------------
   logic [PIX_W-1:0] win_ff [9];
   logic             v2_ff;
   meta_type         meta2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff && (meta1_ff.row >= ROW_W'(2)) && (meta1_ff.col >= COL_W'(2));
      end
      if (wr_en) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3]     <= win_ff[k*3 + 1];
            win_ff[k*3 + 1] <= win_ff[k*3 + 2];
         end
         win_ff[2] <= rd_up_ff;
         win_ff[5] <= rd_mid_ff;
         win_ff[8] <= gray1_ff;
         meta2_ff  <= meta1_ff;
      end
   end

   // ---------------- stage 3: gradients ----------------
   localparam int GW = sobel_pkg::GRAD_W;
   logic [9:0]           gx_pos, gx_neg, gy_pos, gy_neg;
   logic signed [GW-1:0] gx_ff, gy_ff;
   logic                 v3_ff;
   meta_type             meta3_ff;

   assign gx_pos = 10'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + 10'(win_ff[6]);
   assign gx_neg = 10'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + 10'(win_ff[8]);
   assign gy_pos = 10'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + 10'(win_ff[2]);
   assign gy_neg = 10'(win_ff[6]) + {1'b0, win_ff[7], 1'b0} + 10'(win_ff[8]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv && v2_ff) begin
         gx_ff    <= $signed({2'b00, gx_pos}) - $signed({2'b00, gx_neg});
         gy_ff    <= $signed({2'b00, gy_pos}) - $signed({2'b00, gy_neg});
         meta3_ff <= meta2_ff;
      end
   end

   // ---------------- stage 4: squares ----------------
   logic signed [2*GW-1:0]      sqx_full, sqy_full;
   logic [sobel_pkg::SQ_W-1:0]  sqx_ff, sqy_ff;
   logic                        v4_ff;
   meta_type                    meta4_ff;

   assign sqx_full = gx_ff * gx_ff;
   assign sqy_full = gy_ff * gy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv && v3_ff) begin
         sqx_ff   <= sqx_full[sobel_pkg::SQ_W-1:0];
         sqy_ff   <= sqy_full[sobel_pkg::SQ_W-1:0];
         meta4_ff <= meta3_ff;
      end
   end

   // ---------------- stage 5: upper half of the root ----------------
   logic [sobel_pkg::SQ_W-1:0] sq_sum;
   sobel_pkg::root_part_type   root_start;
   sobel_pkg::root_part_type   root_hi;
   sobel_pkg::root_part_type   root_ff;
   logic                       sat_ff;
   logic                       v5_ff;
   meta_type                   meta5_ff;

   assign sq_sum     = sqx_ff + sqy_ff;
   assign root_start = {sq_sum[15:0], 16'd0};
   assign root_hi    = sobel_pkg::isqrt_half(root_start, sobel_pkg::ROOT_BIT_HI);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
      if (adv && v4_ff) begin
         root_ff  <= root_hi;
         // anything at or above 256^2 saturates
         sat_ff   <= (sq_sum[sobel_pkg::SQ_W-1:16] != '0);
         meta5_ff <= meta4_ff;
      end
   end

   // ---------------- output: lower half of root, saturate, threshold ----------------
   sobel_pkg::root_part_type   root_lo;
   logic [PIX_W-1:0]           mag;
   logic [PIX_W-1:0]           edge_in;
   logic                       out_valid_ff;
   logic [ROW_W-1:0]           out_row_ff;
   logic [COL_W-1:0]           out_col_ff;
   logic [PIX_W-1:0]           out_edge_ff;
   logic                       out_done_ff;

   assign root_lo = sobel_pkg::isqrt_half(root_ff, sobel_pkg::ROOT_BIT_LO);

   always_comb begin
      if (sat_ff) begin
         mag = sobel_pkg::PIX_SAT;
      end else begin
         mag = root_lo.res[PIX_W-1:0];
      end
      if (binary_mode_ff) begin
         edge_in = (mag == sobel_pkg::PIX_SAT) ? sobel_pkg::PIX_SAT : sobel_pkg::PIX_ZERO;
      end else begin
         edge_in = mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= v5_ff;
      end
      if (adv && v5_ff) begin
         out_row_ff  <= meta5_ff.row - ROW_W'(2);
         out_col_ff  <= meta5_ff.col - COL_W'(2);
         out_edge_ff <= edge_in;
         out_done_ff <= meta5_ff.done;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_edge_value = out_edge_ff;
   assign rsp_frame_done = out_done_ff;

   // ---------------- assertions ----------------
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_col_ff && row_ff <= last_row_ff)
      else $error("input position beyond frame size");

   a_done_at_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |->
         rsp_out_row == last_row_ff - ROW_W'(2) && rsp_out_col == last_col_ff - COL_W'(2))
      else $error("frame_done off the last window");

   a_result_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_col <= last_col_ff - COL_W'(2) &&
                    rsp_out_row <= last_row_ff - ROW_W'(2))
      else $error("result position in border region");

   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v4_ff) && $stable(v1_ff) && $stable(col_ff))
      else $error("pipeline moved during output stall");

endmodule
